@@ rtl/core/aip_pkg.sv @@
// Shared types and constants of the archive index parser.
// Result beat layout, result kind and status codes, header layout constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

    // Result kinds (travel on m_tuser)
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_SMALL_IDX  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_NO_ENTRIES = 3'd4;

    // Header layout
    localparam int MAGIC_LEN      = 3;   // magic at positions 0..2
    localparam int IDX_SIZE_LAST  = 6;   // index size in 3..6
    localparam int COUNT_LAST     = 10;  // file count in 7..10
    localparam int TABLE_START    = 11;
    localparam int TABLE_BASE     = 7;   // table end = 7 + index size
    localparam int WORD_BYTES     = 4;
    localparam int RECORD_TAIL    = 12;  // pad + offset + size words

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 176;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  name_char;
        logic [31:0] record_number;
        logic [31:0] record_offset;
        logic [31:0] record_size;
        logic [31:0] record_name_length;
        logic [2:0]  parse_status;
        logic [31:0] records_found;
        logic        last_of_run;
    } res_t;

    // Up to two results of one step, in order
    typedef struct packed {
        logic [1:0] count;
        res_t       res_a;
        res_t       res_b;
    } push_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = 8'h70;  // 'p'
            2'd1:    val = 8'h66;  // 'f'
            2'd2:    val = 8'h38;  // '8'
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/archive_index_parser_core.sv @@
// Archive index parser, top level: input register, parser step, result queue.
// Depends on aip_pkg, aip_parser and aip_res_fifo.
//
// Streams an archive one byte per beat, from position 0 (s_tuser marks it and
// restarts parsing at any time). Checks the three-byte magic, reads the
// little-endian index size and file count, then walks the record table and
// returns one beat per name byte, one per finished record (offset, size and
// name length) and a final status beat (ok, bad magic, index too small,
// truncated, no entries) carrying the record count. m_tlast marks the last
// result beat caused by an input byte; bytes that cause nothing (magic,
// header, pad and skipped bytes, or bytes while idle) give no beat.
// Rate: one byte per clock while each byte gives at most one result. A byte
// giving two results (a record closing on the last table byte, or a name byte
// or finished record on a truncating byte) costs two output beats, since the
// result queue delivers one beat per clock. On the way to the first result
// beat, an accepted byte is held in the input register, then the step logic
// writes the result queue. Input stalls only when the queue lacks room for two.
`timescale 1ns / 1ps
`default_nettype none

module archive_index_parser_core #(
    parameter int OUT_DEPTH = 4   // result queue depth, power of two, >= 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // byte input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [aip_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tuser,  // first_byte
    input  wire logic                             s_tlast,  // last_byte
    // result output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] name_char, [39:8] record_number, [71:40] record_offset,
    // [103:72] record_size, [135:104] record_name_length,
    // [138:136] parse_status, [170:139] records_found, [175:171] zero
    output logic [aip_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                            m_tuser,  // [1:0] result_kind
    output logic                                  m_tlast   // last_of_run
);
    import aip_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg, in_last_reg;
    logic       room_for_two, step_fire, s_accept;
    push_t      push;
    res_t       out_res;

    // The step fires only when the queue can absorb a two-result byte
    assign step_fire = in_valid_reg && room_for_two;
    assign s_tready  = !in_valid_reg || step_fire;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) in_valid_next = 1'b1;
        else if (step_fire) in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata[7:0];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    aip_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (step_fire),
        .in_byte    (in_byte_reg),
        .in_first   (in_first_reg),
        .in_last    (in_last_reg),
        .push       (push)
    );

    aip_res_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (m_tready),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_res      (out_res)
    );

    assign m_tdata = {5'b0,
                      out_res.records_found,
                      out_res.parse_status,
                      out_res.record_name_length,
                      out_res.record_size,
                      out_res.record_offset,
                      out_res.record_number,
                      out_res.name_char};
    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.last_of_run;

    // status always closes the run of its byte
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status beat without tlast");

    // an ok status implies at least one record was parsed
    a_ok_has_records: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS && m_tdata[138:136] == ST_OK
        |-> m_tdata[170:139] != 32'd0)
        else $error("ok status with zero records");

    // only the three defined kinds leave the block
    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_NAME || m_tuser == KIND_RECORD
                      || m_tuser == KIND_STATUS))
        else $error("undefined result kind");

endmodule

`default_nettype wire

@@ rtl/core/aip_parser.sv @@
// Parser state and per-byte step logic.
// Holds the header/record walk state; emits up to two results per byte.
// Depends on aip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aip_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_first,
    input  wire logic          in_last,
    output aip_pkg::push_t     push
);
    import aip_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_LEN, PH_NAME, PH_PAD, PH_OFF, PH_SIZE, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase, ph;
    logic [32:0] pos_reg, pos_next, cur_pos;
    logic [31:0] wa_reg, wa_next, cur_wa, wa_shift;
    logic [1:0]  wbc_reg, wbc_next, cur_wbc, wbc_inc;
    logic [32:0] te_reg, te_next, cur_te;
    logic [31:0] exp_reg, exp_next, cur_exp;
    logic [31:0] pc_reg, pc_next, cur_pc;
    logic [31:0] nbl_reg, nbl_next, cur_nbl;
    logic [31:0] hnl_reg, hnl_next, cur_hnl;
    logic [31:0] hoff_reg, hoff_next, cur_hoff;
    logic        fin_reg, fin_next;

    logic        active, word_done, st_valid, body_valid;
    logic [2:0]  st_code;
    logic [33:0] pos_ext, te_ext;
    res_t        body_res, st_res;

    always_comb begin
        // first_byte restarts the walk at the header with cleared state
        if (in_first) begin
            cur_phase = PH_HDR;
            cur_pos   = '0;
            cur_wa    = '0;
            cur_wbc   = '0;
            cur_te    = '0;
            cur_exp   = '0;
            cur_pc    = '0;
            cur_nbl   = '0;
            cur_hnl   = '0;
            cur_hoff  = '0;
        end else begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_wa    = wa_reg;
            cur_wbc   = wbc_reg;
            cur_te    = te_reg;
            cur_exp   = exp_reg;
            cur_pc    = pc_reg;
            cur_nbl   = nbl_reg;
            cur_hnl   = hnl_reg;
            cur_hoff  = hoff_reg;
        end
        active    = in_first || !fin_reg;
        wa_shift  = {in_byte, cur_wa[31:8]};
        wbc_inc   = cur_wbc + 2'd1;
        word_done = (wbc_inc == 2'd0);
        pos_ext   = {1'b0, cur_pos};
        te_ext    = {1'b0, cur_te};

        ph        = cur_phase;
        wa_next   = cur_wa;
        wbc_next  = cur_wbc;
        te_next   = cur_te;
        exp_next  = cur_exp;
        pc_next   = cur_pc;
        nbl_next  = cur_nbl;
        hnl_next  = cur_hnl;
        hoff_next = cur_hoff;
        fin_next  = 1'b0;
        st_valid  = 1'b0;
        st_code   = ST_OK;
        body_valid = 1'b0;
        body_res  = '0;

        if (cur_phase == PH_HDR) begin
            if (cur_pos < 33'(MAGIC_LEN)) begin
                if (in_byte != magic_byte(cur_pos[1:0])) begin
                    st_valid = 1'b1;
                    st_code  = ST_BAD_MAGIC;
                end
            end else begin
                wa_next = wa_shift;
                if (cur_pos == 33'(IDX_SIZE_LAST)) begin
                    te_next = 33'(TABLE_BASE) + {1'b0, wa_shift};
                end
                if (cur_pos == 33'(COUNT_LAST)) begin
                    exp_next = wa_shift;
                    wbc_next = '0;
                    if (cur_te <= 33'(TABLE_START)) begin
                        st_valid = 1'b1;
                        st_code  = ST_SMALL_IDX;
                    end else begin
                        ph = PH_LEN;
                    end
                end
            end
        end else begin
            // record start: stop on count reached or too few table bytes left
            if (ph == PH_LEN && cur_wbc == 2'd0) begin
                if (!(cur_pc < cur_exp && (pos_ext + 34'(WORD_BYTES)) <= te_ext)) begin
                    ph = PH_SKIP;
                end
            end
            case (ph)
                PH_LEN: begin
                    wa_next  = wa_shift;
                    wbc_next = wbc_inc;
                    if (word_done) begin
                        hnl_next = wa_shift;
                        if (pos_ext + 34'(RECORD_TAIL + 1) + {2'b00, wa_shift} > te_ext) begin
                            ph = PH_SKIP;
                        end else if (wa_shift == 32'd0) begin
                            ph = PH_PAD;
                        end else begin
                            nbl_next = wa_shift;
                            ph       = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    body_valid             = 1'b1;
                    body_res.result_kind   = KIND_NAME;
                    body_res.name_char     = in_byte;
                    body_res.record_number = cur_pc;
                    nbl_next               = cur_nbl - 32'd1;
                    if (cur_nbl == 32'd1) ph = PH_PAD;
                end
                PH_PAD: begin
                    wa_next  = wa_shift;
                    wbc_next = wbc_inc;
                    if (word_done) ph = PH_OFF;
                end
                PH_OFF: begin
                    wa_next  = wa_shift;
                    wbc_next = wbc_inc;
                    if (word_done) begin
                        hoff_next = wa_shift;
                        ph        = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    wa_next  = wa_shift;
                    wbc_next = wbc_inc;
                    if (word_done) begin
                        body_valid                  = 1'b1;
                        body_res.result_kind        = KIND_RECORD;
                        body_res.record_number      = cur_pc;
                        body_res.record_offset      = cur_hoff;
                        body_res.record_size        = wa_shift;
                        body_res.record_name_length = cur_hnl;
                        pc_next                     = cur_pc + 32'd1;
                        ph                          = PH_LEN;
                    end
                end
                default: begin
                end
            endcase
            // last table byte closes the run
            if ((cur_pos + 33'd1) == cur_te) begin
                st_valid = 1'b1;
                st_code  = (pc_next != 32'd0) ? ST_OK : ST_NO_ENTRIES;
            end
        end

        if (!st_valid && in_last) begin
            st_valid = 1'b1;
            st_code  = ST_TRUNCATED;
        end
        phase_next = ph;
        if (st_valid) begin
            fin_next   = 1'b1;
            phase_next = PH_IDLE;
        end
        pos_next = cur_pos + 33'd1;

        st_res               = '0;
        st_res.result_kind   = KIND_STATUS;
        st_res.parse_status  = st_code;
        st_res.records_found = pc_next;
        st_res.last_of_run   = 1'b1;

        push = '0;
        if (step_valid && active) begin
            if (body_valid) begin
                push.res_a             = body_res;
                push.res_a.last_of_run = !st_valid;
                push.res_b             = st_res;
                push.count             = st_valid ? 2'd2 : 2'd1;
            end else begin
                push.res_a = st_res;
                push.count = st_valid ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            wa_reg    <= '0;
            wbc_reg   <= '0;
            te_reg    <= '0;
            exp_reg   <= '0;
            pc_reg    <= '0;
            nbl_reg   <= '0;
            hnl_reg   <= '0;
            hoff_reg  <= '0;
            fin_reg   <= 1'b1;
        end else if (step_valid && active) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            wa_reg    <= wa_next;
            wbc_reg   <= wbc_next;
            te_reg    <= te_next;
            exp_reg   <= exp_next;
            pc_reg    <= pc_next;
            nbl_reg   <= nbl_next;
            hnl_reg   <= hnl_next;
            hoff_reg  <= hoff_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/aip_res_fifo.sv @@
// Result queue: takes up to two results per cycle, gives one beat per cycle when popped.
// Depth must be a power of two, at least 2; the block does not enforce it. Depends on aip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aip_res_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  aip_pkg::push_t     push,
    input  wire logic          pop,
    output logic               room_for_two,
    output logic               out_valid,
    output aip_pkg::res_t      out_res
);
    import aip_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_inc;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign wr_ptr_inc   = wr_ptr_reg + PTR_W'(1);
    assign out_valid    = (count_reg != '0);
    assign out_res      = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign do_pop       = pop && out_valid;
    assign count_next   = count_reg + CNT_W'(push.count) - CNT_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.res_a;
        if (push.count == 2'd2) mem[wr_ptr_inc] <= push.res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ test/aip_result_checker.sv @@
// Result checker for the archive index parser: follows the byte and result
// streams, predicts the beats of every accepted byte and compares in order.
// Depends on aip_pkg for the result layout, kinds and status codes.
`timescale 1ns / 1ps

module aip_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [aip_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // first_byte
    input  logic                            s_tlast,   // last_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] name_char, [39:8] record_number, [71:40] record_offset,
    // [103:72] record_size, [135:104] record_name_length,
    // [138:136] parse_status, [170:139] records_found, [175:171] zero
    input  logic [aip_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [1:0]                      m_tuser,   // [1:0] result_kind
    input  logic                            m_tlast,   // last_of_run
    output int                              pending,
    output int                              failures
);
    import aip_pkg::*;

    // archive header layout
    localparam logic [23:0] MAGIC_SEQ   = 24'h38_66_70;  // 'p' 'f' '8', first in low byte
    localparam int          MAGIC_BYTES = 3;
    localparam int          SIZE_END    = 6;
    localparam int          COUNT_END   = 10;
    localparam int          TBL_FIRST   = 11;
    localparam int          TBL_BIAS    = 7;

    typedef enum logic [3:0] {
        P_IDLE, P_HEADER, P_NAME_LEN, P_NAME, P_PAD, P_OFFSET, P_SIZE, P_SKIP
    } walk_phase_t;

    walk_phase_t ph;
    logic [32:0] byte_pos;
    logic [31:0] word_acc;
    logic [1:0]  word_fill;
    logic [32:0] tbl_end;
    logic [31:0] want_count;
    logic [31:0] rec_count;
    logic [31:0] name_left;
    logic [31:0] rec_name_len;
    logic [31:0] rec_offset;
    bit          idle;

    res_t expected_beats[$];
    int   beats_seen;

    function automatic void clear_parser();
        ph           = P_IDLE;
        byte_pos     = '0;
        word_acc     = '0;
        word_fill    = '0;
        tbl_end      = '0;
        want_count   = '0;
        rec_count    = '0;
        name_left    = '0;
        rec_name_len = '0;
        rec_offset   = '0;
        idle         = 1'b1;
    endfunction

    // little-endian word assembly; true once the fourth byte is in
    function automatic bit shift_in(input logic [7:0] b);
        word_acc  = {b, word_acc[31:8]};
        word_fill = word_fill + 2'd1;
        return word_fill == 2'd0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input bit first, input bit lst);
        res_t        outs[2];
        int          n;
        bit          has_st;
        logic [2:0]  st;
        logic [32:0] pos;

        n      = 0;
        has_st = 1'b0;
        st     = ST_OK;
        if (first) begin
            clear_parser();
            idle = 1'b0;
            ph   = P_HEADER;
        end else if (idle) begin
            return;
        end
        pos = byte_pos;

        if (ph == P_HEADER) begin
            if (pos < MAGIC_BYTES) begin
                if (b != MAGIC_SEQ[8*pos[1:0] +: 8]) begin
                    has_st = 1'b1;
                    st     = ST_BAD_MAGIC;
                end
            end else begin
                word_acc = {b, word_acc[31:8]};
                if (pos == SIZE_END)
                    tbl_end = 33'(TBL_BIAS) + {1'b0, word_acc};
                if (pos == COUNT_END) begin
                    want_count = word_acc;
                    word_fill  = '0;
                    if (tbl_end <= TBL_FIRST) begin
                        has_st = 1'b1;
                        st     = ST_SMALL_IDX;
                    end else begin
                        ph = P_NAME_LEN;
                    end
                end
            end
        end else begin
            // record start: stop the walk on count reached or under a word left
            if (ph == P_NAME_LEN && word_fill == 2'd0 &&
                !(rec_count < want_count && {1'b0, pos} + 34'd4 <= {1'b0, tbl_end}))
                ph = P_SKIP;
            case (ph)
                P_NAME_LEN: if (shift_in(b)) begin
                    rec_name_len = word_acc;
                    // name + pad + offset + size must fit before the table end
                    if ({2'b0, pos} + 35'd13 + {3'b0, word_acc} > {2'b0, tbl_end})
                        ph = P_SKIP;
                    else if (word_acc == '0)
                        ph = P_PAD;
                    else begin
                        name_left = word_acc;
                        ph        = P_NAME;
                    end
                end
                P_NAME: begin
                    outs[n]               = '0;
                    outs[n].result_kind   = KIND_NAME;
                    outs[n].name_char     = b;
                    outs[n].record_number = rec_count;
                    n++;
                    name_left = name_left - 32'd1;
                    if (name_left == '0) ph = P_PAD;
                end
                P_PAD: if (shift_in(b)) ph = P_OFFSET;
                P_OFFSET: if (shift_in(b)) begin
                    rec_offset = word_acc;
                    ph         = P_SIZE;
                end
                P_SIZE: if (shift_in(b)) begin
                    outs[n]                    = '0;
                    outs[n].result_kind        = KIND_RECORD;
                    outs[n].record_number      = rec_count;
                    outs[n].record_offset      = rec_offset;
                    outs[n].record_size        = word_acc;
                    outs[n].record_name_length = rec_name_len;
                    n++;
                    rec_count = rec_count + 32'd1;
                    ph        = P_NAME_LEN;
                end
                default: ;
            endcase
            if ({1'b0, pos} + 34'd1 == {1'b0, tbl_end}) begin
                has_st = 1'b1;
                st     = (rec_count != '0) ? ST_OK : ST_NO_ENTRIES;
            end
        end

        if (!has_st && lst) begin
            has_st = 1'b1;
            st     = ST_TRUNCATED;
        end
        if (has_st) begin
            outs[n]               = '0;
            outs[n].result_kind   = KIND_STATUS;
            outs[n].parse_status  = st;
            outs[n].records_found = rec_count;
            n++;
            idle = 1'b1;
            ph   = P_IDLE;
        end
        byte_pos = pos + 33'd1;
        if (n > 0) outs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_beats.insert(expected_beats.size(), outs[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: result beat %0d, %s: got %0h, want %0h",
                 $time, beats_seen, what, got, want);
        failures++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            clear_parser();
            expected_beats.delete();
            beats_seen = 0;
            failures   = 0;
        end else begin
            if (s_tvalid && s_tready) parse_byte(s_tdata[7:0], s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing expected, kind", 32'(m_tuser), '0);
                end else begin
                    want = expected_beats.pop_front();
                    check_field("result_kind", 32'(m_tuser), 32'(want.result_kind));
                    check_field("name_char", 32'(m_tdata[7:0]), 32'(want.name_char));
                    check_field("record_number", m_tdata[39:8], want.record_number);
                    check_field("record_offset", m_tdata[71:40], want.record_offset);
                    check_field("record_size", m_tdata[103:72], want.record_size);
                    check_field("record_name_length", m_tdata[135:104],
                                want.record_name_length);
                    check_field("parse_status", 32'(m_tdata[138:136]),
                                32'(want.parse_status));
                    check_field("records_found", m_tdata[170:139], want.records_found);
                    check_field("tdata fill", 32'(m_tdata[175:171]), '0);
                    check_field("last_of_run", 32'(m_tlast), 32'(want.last_of_run));
                end
                beats_seen++;
            end
        end
        pending = expected_beats.size();
    end

endmodule

@@ test/tb_archive_index_parser_core.sv @@
// Testbench top of the archive index parser: drives archive byte streams
// (directed corner cases, then random archives) and gives the verdict.
// Depends on aip_pkg, archive_index_parser_core and aip_result_checker.
`timescale 1ns / 1ps

module tb_archive_index_parser_core;

    localparam int ITEMS       = 1900;  // bytes to send
    localparam int CALM_TAIL   = 250;   // last bytes sent without idling
    localparam int STALL_LIMIT = 200;   // cycles without any beat before giving up
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_8 = 8'h38;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [aip_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [aip_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;

    int         pending;
    int         failures;
    bit         gaps_on     = 1'b1;
    int         bytes_sent  = 0;
    int         quiet_cycles = 0;
    int         stall_left  = 0;
    logic [7:0] arc[$];    // archive image being built

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    archive_index_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    aip_result_checker i_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .pending  (pending),
        .failures (failures)
    );

    // receiver backpressure in random bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // appends one byte to the archive image
    task automatic put_byte(input logic [7:0] b);
        arc.insert(arc.size(), b);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) put_byte(w[8*k +: 8]);
    endtask

    task automatic start_header(input logic [31:0] idx_size, input logic [31:0] count);
        arc.delete();
        put_byte(CH_P);
        put_byte(CH_F);
        put_byte(CH_8);
        add_word(idx_size);
        add_word(count);
    endtask

    // one input beat; called and returns at a falling edge
    task automatic send_beat(input logic [7:0] data, input bit first, input bit lst);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_archive(input int len, input int last_at);
        for (int i = 0; i < len; i++) send_beat(arc[i], i == 0, i == last_at);
    endtask

    initial begin
        int          nrec;
        int          len;
        int          last_at;
        int          mode;
        logic [31:0] nlen;
        logic [31:0] cnt;
        logic [31:0] isz;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // bytes before any position 0 are ignored, last included
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        // bad magic on the first byte, then a stray byte while idle
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(CH_P, 1'b0, 1'b0);
        // restart inside the magic, then a bad third byte
        send_beat(CH_P, 1'b1, 1'b0);
        send_beat(CH_F, 1'b0, 1'b0);
        send_beat(CH_P, 1'b1, 1'b0);
        send_beat(CH_F, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        // cut off right after position 0
        send_beat(CH_P, 1'b1, 1'b1);
        // index size 4 is too small; last on the same byte changes nothing
        start_header(32'd4, '1);
        send_archive(arc.size(), arc.size() - 1);
        // largest index size and count, cut inside the first name length
        start_header('1, '1);
        put_byte(8'hFF);
        send_archive(arc.size(), arc.size() - 1);

        // random archives: mostly well formed, some broken headers
        while (bytes_sent < ITEMS) begin
            gaps_on = (bytes_sent < ITEMS - CALM_TAIL) && ($urandom_range(0, 4) != 0);
            mode    = $urandom_range(0, 9);
            if (mode < 8) begin
                nrec = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                start_header('0, '0);
                for (int r = 0; r < nrec; r++) begin
                    // now and then a name length that overruns the table
                    nlen = ($urandom_range(0, 11) == 0) ? $urandom : $urandom_range(0, 6);
                    add_word(nlen);
                    repeat ((nlen > 6) ? $urandom_range(0, 3) : nlen)
                        put_byte(8'($urandom));
                    add_word($urandom);
                    add_word(rand_word());
                    add_word(rand_word());
                end
                // spare table bytes exercise the walk stops
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
                case ($urandom_range(0, 5))
                    0:       cnt = $urandom_range(0, nrec);
                    1:       cnt = nrec + $urandom_range(1, 3);
                    2:       cnt = '1;
                    default: cnt = nrec;
                endcase
                isz = arc.size() - 7;
                for (int k = 0; k < 4; k++) begin
                    arc[3+k] = isz[8*k +: 8];
                    arc[7+k] = cnt[8*k +: 8];
                end
            end else if (mode == 8) begin
                start_header($urandom_range(0, 4), rand_word());
            end else begin
                start_header(rand_word(), rand_word());
                arc[$urandom_range(0, 2)] = 8'($urandom);
            end
            // file data after the table is ignored
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom));

            len     = arc.size();
            last_at = len - 1;
            case ($urandom_range(0, 7))
                0: last_at = $urandom_range(0, len - 1);  // truncated early
                1: begin                                  // cut, next archive restarts
                    len     = $urandom_range(1, len);
                    last_at = -1;
                end
                default: ;
            endcase
            send_archive(len, last_at);
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
